@@ src/aerp_pkg.sv @@
// ----------------------------------------------------------------------------
// aerp_pkg
// Types, codes and constants shared by the ARM relocation patcher.
// ----------------------------------------------------------------------------
package aerp_pkg;

  // relocation type codes
  localparam logic [7:0] R_ABS32    = 8'd2;
  localparam logic [7:0] R_THM_CALL = 8'd10;
  localparam logic [7:0] R_CALL     = 8'd28;
  localparam logic [7:0] R_JUMP24   = 8'd29;
  localparam logic [7:0] R_TARGET1  = 8'd38;
  localparam logic [7:0] R_TLS_IE32 = 8'd107;
  localparam logic [7:0] R_TLS_LE32 = 8'd108;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_THM_RANGE = 3'd1;
  localparam logic [2:0] ST_NO_VENEER = 3'd2;
  localparam logic [2:0] ST_J24_RANGE = 3'd3;
  localparam logic [2:0] ST_CALL_RANGE = 3'd4;
  localparam logic [2:0] ST_UNKNOWN   = 3'd5;

  // register indexes
  localparam logic [1:0] REG_LOAD_BASE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_SIZE  = 2'd1;
  localparam logic [1:0] REG_BUFFER_SIZE = 2'd2;

  localparam logic [31:0] TLS_TCB_BYTES = 32'd8;
  localparam logic [31:0] VENEER_LDR_PC = 32'hE51FF004;
  localparam logic [31:0] BLX_IMM_BASE  = 32'hFA000000;
  localparam logic [31:0] VENEER_BYTES  = 32'd8;

  localparam logic signed [31:0] THM_LIMIT = 32'sh003FFFFF;
  localparam logic signed [31:0] ARM_LIMIT = 32'sh007FFFFF;

  // registered input item, place already formed
  typedef struct packed {
    logic        restart;
    logic [7:0]  rtype;
    logic [31:0] place;
    logic [31:0] sym;
    logic        ext;
    logic [31:0] cur;
  } item_t;

  typedef struct packed {
    logic        we;
    logic [31:0] addr;
    logic [31:0] data;
    logic        half;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [2:0]  res;
    logic [1:0]  count;
    logic [31:0] veneer_next;
  } calc_t;

  function automatic logic out_of_range(logic [31:0] j, logic signed [31:0] lim);
    logic signed [31:0] s;
    s = $signed(j);
    return (s > lim) || (s <= -lim);
  endfunction

endpackage

@@ src/aerp_calc.sv @@
// ----------------------------------------------------------------------------
// aerp_calc
// Decodes one relocation item into up to three write results and the
// updated veneer offset.
// ----------------------------------------------------------------------------
module aerp_calc (
  input  aerp_pkg::item_t item,
  input  logic [31:0]     load_base,
  input  logic [31:0]     image_size,
  input  logic [31:0]     buffer_size,
  input  logic [31:0]     veneer_offset,
  output aerp_pkg::calc_t calc
);

  logic [31:0] vo_eff;
  logic [31:0] image_align;
  logic [31:0] dest;
  logic        to_arm;
  logic        no_space;
  logic [31:0] j_thm;
  logic [31:0] j_j24;
  logic [31:0] j_call;
  logic [31:0] abs_data;
  aerp_pkg::res_t fail_r;

  assign image_align = (image_size + 32'd3) & ~32'd3;
  assign vo_eff      = item.restart ? image_align : veneer_offset;
  assign to_arm      = ~item.sym[0];
  assign no_space    = ({1'b0, vo_eff} + {1'b0, aerp_pkg::VENEER_BYTES}) >
                       {1'b0, buffer_size};
  assign dest        = to_arm ? item.sym : load_base + vo_eff;
  assign j_thm       = item.sym - item.place - (to_arm ? 32'd2 : 32'd4);
  assign j_j24       = dest - item.place - 32'd6;
  assign j_call      = item.sym - item.place - (to_arm ? 32'd6 : 32'd8);
  assign abs_data    = item.ext ? item.sym : item.cur + load_base;

  always_comb begin
    fail_r = '0;
    fail_r.last = 1'b1;
    calc = '0;
    calc.count = 2'd1;
    calc.veneer_next = vo_eff;
    calc.res[0].last = 1'b1;
    if (item.rtype inside {aerp_pkg::R_ABS32, aerp_pkg::R_TARGET1,
                           aerp_pkg::R_TLS_IE32}) begin
      calc.res[0].we   = 1'b1;
      calc.res[0].addr = item.place;
      calc.res[0].data = abs_data;
    end else if (item.rtype == aerp_pkg::R_TLS_LE32) begin
      calc.res[0].we   = 1'b1;
      calc.res[0].addr = item.place;
      calc.res[0].data = item.sym + aerp_pkg::TLS_TCB_BYTES;
    end else if (!(item.rtype inside {aerp_pkg::R_THM_CALL, aerp_pkg::R_CALL,
                                      aerp_pkg::R_JUMP24})) begin
      calc.res[0] = fail_r;
      calc.res[0].status = aerp_pkg::ST_UNKNOWN;
    end else if (!item.ext) begin
      // local branch: nothing to patch
    end else if (item.rtype == aerp_pkg::R_THM_CALL) begin
      if (aerp_pkg::out_of_range(j_thm, aerp_pkg::THM_LIMIT)) begin
        calc.res[0] = fail_r;
        calc.res[0].status = aerp_pkg::ST_THM_RANGE;
      end else begin
        calc.count = 2'd2;
        calc.res[0].we   = 1'b1;
        calc.res[0].addr = item.place;
        calc.res[0].data = {16'd0, 5'b11110, j_thm[22:12]};
        calc.res[0].half = 1'b1;
        calc.res[0].last = 1'b0;
        calc.res[1].we   = 1'b1;
        calc.res[1].addr = item.place + 32'd2;
        calc.res[1].data = to_arm ? {16'd0, 5'b11101, j_thm[11:2], 1'b0}
                                  : {16'd0, 5'b11111, j_thm[11:1]};
        calc.res[1].half = 1'b1;
        calc.res[1].last = 1'b1;
      end
    end else if (item.rtype == aerp_pkg::R_JUMP24) begin
      if (!to_arm && no_space) begin
        calc.res[0] = fail_r;
        calc.res[0].status = aerp_pkg::ST_NO_VENEER;
      end else if (aerp_pkg::out_of_range(j_j24, aerp_pkg::ARM_LIMIT)) begin
        calc.res[0] = fail_r;
        calc.res[0].status = aerp_pkg::ST_J24_RANGE;
      end else if (to_arm) begin
        calc.res[0].we   = 1'b1;
        calc.res[0].addr = item.place;
        calc.res[0].data = {item.cur[31:24], j_j24[25:2]};
      end else begin
        calc.count = 2'd3;
        calc.veneer_next = vo_eff + aerp_pkg::VENEER_BYTES;
        calc.res[0].we   = 1'b1;
        calc.res[0].addr = dest;
        calc.res[0].data = aerp_pkg::VENEER_LDR_PC;
        calc.res[0].last = 1'b0;
        calc.res[1].we   = 1'b1;
        calc.res[1].addr = dest + 32'd4;
        calc.res[1].data = item.sym;
        calc.res[2].we   = 1'b1;
        calc.res[2].addr = item.place;
        calc.res[2].data = {item.cur[31:24], j_j24[25:2]};
        calc.res[2].last = 1'b1;
      end
    end else begin
      if (aerp_pkg::out_of_range(j_call, aerp_pkg::ARM_LIMIT)) begin
        calc.res[0] = fail_r;
        calc.res[0].status = aerp_pkg::ST_CALL_RANGE;
      end else begin
        calc.res[0].we   = 1'b1;
        calc.res[0].addr = item.place;
        calc.res[0].data = to_arm ? {item.cur[31:24], j_call[25:2]}
                                  : (aerp_pkg::BLX_IMM_BASE |
                                     {7'd0, j_call[1], j_call[25:2]});
      end
    end
  end

endmodule

@@ src/arm_elf_relocation_patcher.sv @@
// ----------------------------------------------------------------------------
// arm_elf_relocation_patcher
// Applies ARM ELF32 relocations as a stream of memory write items.
// ----------------------------------------------------------------------------
// One relocation item is accepted per cycle into an input register while the
// result buffer can take it; the decoded item is then loaded into the buffer as
// one, two or three write items. Single-write items sustain one item per cycle
// while m_tready is high. A Thumb call gives two write items and a JUMP24
// through a veneer three; the buffer drains one write per cycle while m_tready
// is high, and a further item waits in the input register. The user must write
// the registers only while no item is in flight; the block does not enforce it.
module arm_elf_relocation_patcher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // restart, target_offset, symbol_value, symbol_external, current_word, pad
  input  logic [103:0] s_tdata,
  // reloc_type
  input  logic [7:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // write_enable, write_address, write_data, write_half, pad
  output logic [71:0]  m_tdata,
  // status
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0] load_base;
  logic [31:0] image_size;
  logic [31:0] buffer_size;
  logic [31:0] veneer_offset;

  logic            a_valid;
  aerp_pkg::item_t a_item;
  aerp_pkg::calc_t calc;

  aerp_pkg::res_t [2:0] rbuf;
  logic [1:0]           cnt;

  logic s_fire;
  logic buf_done;
  logic can_load;
  logic a_consume;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_base   <= '0;
      image_size  <= '0;
      buffer_size <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        aerp_pkg::REG_LOAD_BASE:   load_base   <= pwdata;
        aerp_pkg::REG_IMAGE_SIZE:  image_size  <= pwdata;
        aerp_pkg::REG_BUFFER_SIZE: buffer_size <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      aerp_pkg::REG_LOAD_BASE:   prdata = load_base;
      aerp_pkg::REG_IMAGE_SIZE:  prdata = image_size;
      aerp_pkg::REG_BUFFER_SIZE: prdata = buffer_size;
      default:                   prdata = '0;
    endcase
  end

  // handshake control
  assign m_tvalid  = (cnt != 2'd0);
  assign buf_done  = m_tvalid && m_tready && rbuf[0].last;
  assign can_load  = !m_tvalid || buf_done;
  assign a_consume = a_valid && can_load;
  assign s_tready  = !a_valid || can_load;
  assign s_fire    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_fire) begin
      a_valid <= 1'b1;
    end else if (a_consume) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_item.restart <= s_tdata[0];
      a_item.rtype   <= s_tuser;
      a_item.place   <= load_base + s_tdata[32:1];
      a_item.sym     <= s_tdata[64:33];
      a_item.ext     <= s_tdata[65];
      a_item.cur     <= s_tdata[97:66];
    end
  end

  aerp_calc u_calc (
    .item          (a_item),
    .load_base     (load_base),
    .image_size    (image_size),
    .buffer_size   (buffer_size),
    .veneer_offset (veneer_offset),
    .calc          (calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      veneer_offset <= '0;
    end else if (a_consume) begin
      veneer_offset <= calc.veneer_next;
    end
  end

  // result buffer: head in slot 0, shifts on each taken item
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (a_consume) begin
      cnt <= calc.count;
    end else if (buf_done) begin
      cnt <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_consume) begin
      rbuf <= calc.res;
    end else if (m_tvalid && m_tready) begin
      rbuf[0] <= rbuf[1];
      rbuf[1] <= rbuf[2];
    end
  end

  assign m_tdata = {6'd0, rbuf[0].half, rbuf[0].data, rbuf[0].addr, rbuf[0].we};
  assign m_tuser = rbuf[0].status;
  assign m_tlast = rbuf[0].last;

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != aerp_pkg::ST_OK) |-> m_tlast && !m_tdata[0])
    else $error("error result must be a single item with no write");

  a_multi_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> cnt > 2'd1)
    else $error("non-final result without a following one");

  a_load: assert property (@(posedge clk) disable iff (rst)
    a_consume |=> m_tvalid)
    else $error("decoded item not loaded into result buffer");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> s_tready)
    else $error("input stalled with empty input register");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the ARM relocation patcher.
// ----------------------------------------------------------------------------
// Relocation items are fed from a queue through the input stream while a
// local copy of the patch rules forms the expected write items on every
// accepted item. The output stream is compared field by field, in order.
// Both sides idle at random, the receiver holds off for long stretches, and
// the APB registers are changed between phases, extremes included.
module tb;
  import aerp_pkg::*;

  typedef struct packed {
    logic        restart;
    logic [7:0]  rtype;
    logic [31:0] offs;
    logic [31:0] sym;
    logic        ext;
    logic [31:0] word;
  } reloc_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // restart, target_offset, symbol_value, symbol_external, current_word, pad
  logic [103:0] s_tdata = '0;
  // reloc_type
  logic [7:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // write_enable, write_address, write_data, write_half, pad
  logic [71:0]  m_tdata;
  // status
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  arm_elf_relocation_patcher dut (.*);

  // local copy of the registers and the veneer pointer
  logic [31:0] cfg_load_base = '0;
  logic [31:0] cfg_image_size = '0;
  logic [31:0] cfg_buffer_size = '0;
  logic [31:0] veneer_at = '0;

  reloc_t pending[$];
  res_t   exp_writes[$];
  reloc_t drv_item;
  res_t   want;
  res_t   got;
  bit     bad;
  bit     in_done = 1'b0;
  bit     no_gaps = 1'b0;
  int     errors = 0;
  int     n_acc = 0;
  int     long_at = 60;
  int     tx_gap = 0;
  int     rx_gap = 0;
  int     long_cnt = 0;

  always #1 clk = ~clk;

  function automatic bit too_far(logic [31:0] j, int lim);
    int s;
    s = $signed(j);
    return (s > lim) || (s <= -lim);
  endfunction

  task automatic queue_write(bit we, logic [31:0] addr, logic [31:0] data, bit half,
                             logic [2:0] st, bit last);
    res_t r;
    r.we = we;
    r.addr = addr;
    r.data = data;
    r.half = half;
    r.status = st;
    r.last = last;
    exp_writes.push_back(r);
  endtask

  // expected write items for one relocation
  task automatic apply_reloc(reloc_t it);
    logic [31:0] place, dest, j, hi, lo, bw;
    bit to_arm, veneer;
    if (it.restart) veneer_at = (cfg_image_size + 32'd3) & ~32'd3;
    place = cfg_load_base + it.offs;
    to_arm = !it.sym[0];
    case (it.rtype)
      R_ABS32, R_TARGET1, R_TLS_IE32: begin
        queue_write(1, place, it.ext ? it.sym : it.word + cfg_load_base, 0, ST_OK, 1);
      end
      R_TLS_LE32: begin
        queue_write(1, place, it.sym + TLS_TCB_BYTES, 0, ST_OK, 1);
      end
      R_THM_CALL, R_CALL, R_JUMP24: begin
        if (!it.ext) begin
          queue_write(0, '0, '0, 0, ST_OK, 1);
        end else if (it.rtype == R_THM_CALL) begin
          j = it.sym - place - (to_arm ? 32'd2 : 32'd4);
          if (too_far(j, 32'h3FFFFF)) begin
            queue_write(0, '0, '0, 0, ST_THM_RANGE, 1);
          end else begin
            hi = 32'hF000 | (32'h07FF & (j >> 12));
            lo = to_arm ? (32'hE800 | (32'h07FE & (j >> 1)))
                        : (32'hF800 | (32'h07FF & (j >> 1)));
            queue_write(1, place, hi, 1, ST_OK, 0);
            queue_write(1, place + 32'd2, lo, 1, ST_OK, 1);
          end
        end else if (it.rtype == R_JUMP24) begin
          veneer = !to_arm;
          dest = veneer ? cfg_load_base + veneer_at : it.sym;
          if (veneer && ({1'b0, veneer_at} + 33'd8 > {1'b0, cfg_buffer_size})) begin
            queue_write(0, '0, '0, 0, ST_NO_VENEER, 1);
          end else begin
            j = dest - place - 32'd6;
            if (too_far(j, 32'h7FFFFF)) begin
              queue_write(0, '0, '0, 0, ST_J24_RANGE, 1);
            end else begin
              if (veneer) begin
                queue_write(1, dest, VENEER_LDR_PC, 0, ST_OK, 0);
                queue_write(1, dest + 32'd4, it.sym, 0, ST_OK, 0);
                veneer_at = veneer_at + 32'd8;
              end
              bw = (it.word & 32'hFF000000) | ((j >> 2) & 32'h00FFFFFF);
              queue_write(1, place, bw, 0, ST_OK, 1);
            end
          end
        end else begin
          j = it.sym - place - (to_arm ? 32'd6 : 32'd8);
          if (too_far(j, 32'h7FFFFF)) begin
            queue_write(0, '0, '0, 0, ST_CALL_RANGE, 1);
          end else begin
            if (to_arm) bw = (it.word & 32'hFF000000) | ((j >> 2) & 32'h00FFFFFF);
            else bw = BLX_IMM_BASE | ((j >> 2) & 32'h00FFFFFF) | ((j & 32'd2) << 23);
            queue_write(1, place, bw, 0, ST_OK, 1);
          end
        end
      end
      default: begin
        queue_write(0, '0, '0, 0, ST_UNKNOWN, 1);
      end
    endcase
  endtask

  task automatic queue_reloc(bit restart, logic [7:0] rtype, logic [31:0] offs,
                             logic [31:0] sym, bit ext, logic [31:0] word);
    reloc_t it;
    it.restart = restart;
    it.rtype = rtype;
    it.offs = offs;
    it.sym = sym;
    it.ext = ext;
    it.word = word;
    pending.push_back(it);
  endtask

  // mostly well-formed entries: places inside the image, branch targets near
  // the place or at the edge of the branch range
  function automatic reloc_t make_reloc();
    reloc_t it;
    logic [31:0] place, lim;
    bit branch;
    branch = 1'b0;
    case ($urandom_range(0, 19))
      0, 1, 2: it.rtype = R_ABS32;
      3: it.rtype = R_TARGET1;
      4: it.rtype = R_TLS_IE32;
      5: it.rtype = R_TLS_LE32;
      6, 7, 8: begin
        it.rtype = R_THM_CALL;
        branch = 1'b1;
      end
      9, 10, 11: begin
        it.rtype = R_CALL;
        branch = 1'b1;
      end
      12, 13, 14, 15, 16: begin
        it.rtype = R_JUMP24;
        branch = 1'b1;
      end
      default: it.rtype = 8'($urandom_range(0, 255));
    endcase
    it.restart = ($urandom_range(0, 24) == 0);
    if ($urandom_range(0, 9) == 0) it.offs = $urandom;
    else it.offs = $urandom_range(0, cfg_image_size);
    if ($urandom_range(0, 4) != 0) it.offs[1:0] = 2'b00;
    it.word = $urandom;
    it.sym = $urandom;
    if (branch) begin
      it.ext = ($urandom_range(0, 4) != 0);
      place = cfg_load_base + it.offs;
      lim = $urandom_range(0, 1) ? 32'h400000 : 32'h800000;
      case ($urandom_range(0, 5))
        0, 1, 2: it.sym = place + $urandom_range(0, 32'h3FFFF) - 32'h20000;
        3: it.sym = place + lim + $urandom_range(0, 16) - 32'd8;
        4: it.sym = place - lim + $urandom_range(0, 16) - 32'd8;
        default: ;
      endcase
      if (it.rtype == R_JUMP24 && $urandom_range(0, 9) < 4) it.sym[0] = 1'b1;
      else it.sym[0] = $urandom_range(0, 1);
    end else begin
      it.ext = $urandom_range(0, 1);
    end
    return it;
  endfunction

  // APB write, then read back
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_LOAD_BASE: cfg_load_base = value;
      REG_IMAGE_SIZE: cfg_image_size = value;
      REG_BUFFER_SIZE: cfg_buffer_size = value;
      default: ;
    endcase
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      errors++;
      if (errors < 50)
        $display("%0t: reg %0d read expected %h got %h", $time, idx, value, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || s_tvalid || exp_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup_phase(logic [31:0] lb, logic [31:0] isz, logic [31:0] bsz);
    wait_idle();
    write_reg(REG_LOAD_BASE, lb);
    write_reg(REG_IMAGE_SIZE, isz);
    write_reg(REG_BUFFER_SIZE, bsz);
  endtask

  task automatic queue_random(int n);
    reloc_t it;
    for (int i = 0; i < n; i++) begin
      it = make_reloc();
      if (i == 0) it.restart = 1'b1;
      pending.push_back(it);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v,
                             inout bit flag);
    if (want_v !== got_v) begin
      if (errors < 50)
        $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
      flag = 1'b1;
    end
  endtask

  // input acceptance feeds the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      apply_reloc(drv_item);
      in_done = 1'b1;
      n_acc++;
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !in_done)) begin
      in_done = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0 && !no_gaps && $urandom_range(0, 9) == 0) begin
        tx_gap = $urandom_range(0, 10);
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        drv_item = pending.pop_front();
        s_tdata <= {6'b0, drv_item.word, drv_item.ext, drv_item.sym, drv_item.offs,
                    drv_item.restart};
        s_tuser <= drv_item.rtype;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off every 200 items
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_cnt > 0) begin
      long_cnt--;
      m_tready <= 1'b0;
    end else if (!no_gaps && n_acc >= long_at) begin
      long_cnt = 79;
      long_at = long_at + 200;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // output check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.we = m_tdata[0];
      got.addr = m_tdata[32:1];
      got.data = m_tdata[64:33];
      got.half = m_tdata[65];
      got.status = m_tuser;
      got.last = m_tlast;
      if (exp_writes.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t: unexpected item, expected none got %h/%h", $time, m_tdata, m_tuser);
      end else begin
        want = exp_writes.pop_front();
        bad = 1'b0;
        check_field("write_enable", 32'(want.we), 32'(got.we), bad);
        check_field("write_address", want.addr, got.addr, bad);
        check_field("write_data", want.data, got.data, bad);
        check_field("write_half", 32'(want.half), 32'(got.half), bad);
        check_field("status", 32'(want.status), 32'(got.status), bad);
        check_field("last", 32'(want.last), 32'(got.last), bad);
        if (bad) errors++;
      end
    end
  end

  initial begin
    #1000000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    logic [31:0] lb, p, isz;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // room for two veneers after a 4 KB image
    lb = 32'h0200_0000;
    setup_phase(lb, 32'h1000, 32'h1010);
    queue_reloc(1, R_ABS32, 32'h10, 32'h1234_5679, 1, $urandom);
    queue_reloc(0, R_ABS32, 32'h14, 32'h0, 0, 32'h0000_1000);
    queue_reloc(0, R_TARGET1, 32'h18, 32'hFFFF_FFFF, 1, 32'h0);
    queue_reloc(0, R_TLS_IE32, 32'h1C, 32'h0, 0, 32'hFFFF_FFFF);
    queue_reloc(0, R_TLS_LE32, 32'h20, 32'hFFFF_FFFC, 0, 32'h0);
    queue_reloc(0, 8'd0, 32'h24, $urandom, 1, $urandom);
    queue_reloc(0, 8'hFF, 32'h24, $urandom, 0, $urandom);
    p = lb + 32'h40;
    queue_reloc(0, R_THM_CALL, 32'h40, lb + 32'h100, 0, $urandom);
    queue_reloc(0, R_THM_CALL, 32'h40, p + 32'd2 + 32'h3FFFFE, 1, $urandom);
    queue_reloc(0, R_THM_CALL, 32'h40, p + 32'd2 + 32'h400000, 1, $urandom);
    queue_reloc(0, R_THM_CALL, 32'h40, p + 32'd4 + 32'h3FFFFF, 1, $urandom);
    queue_reloc(0, R_THM_CALL, 32'h40, p + 32'd4 - 32'h3FFFFF, 1, $urandom);
    queue_reloc(0, R_CALL, 32'h40, p + 32'h1000, 0, $urandom);
    queue_reloc(0, R_CALL, 32'h40, p + 32'h1000, 1, $urandom);
    queue_reloc(0, R_CALL, 32'h40, p + 32'd8 + 32'h1003, 1, $urandom);
    queue_reloc(0, R_CALL, 32'h40, p + 32'd6 + 32'h800000, 1, $urandom);
    queue_reloc(0, R_JUMP24, 32'h40, p + 32'h200, 0, $urandom);
    queue_reloc(0, R_JUMP24, 32'h40, p + 32'd6 - 32'h7FFFFE, 1, $urandom);
    queue_reloc(0, R_JUMP24, 32'h40, p + 32'd6 - 32'h800000, 1, $urandom);
    queue_reloc(0, R_JUMP24, 32'h40, p + 32'h301, 1, $urandom);
    queue_reloc(0, R_JUMP24, 32'h44, p + 32'h501, 1, $urandom);
    queue_reloc(0, R_JUMP24, 32'h48, p + 32'h701, 1, $urandom);
    queue_reloc(1, R_JUMP24, 32'h4C, p + 32'h901, 1, $urandom);
    queue_reloc(0, R_JUMP24, 32'h4000_0000, p + 32'hB01, 1, $urandom);
    queue_reloc(0, R_ABS32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    queue_random(100);

    // top of the address space; one veneer fits, then the exact
    // end-of-buffer check must not wrap
    setup_phase(32'hFFFF_FFFF, 32'hFFFF_FFF1, 32'hFFFF_FFFF);
    queue_random(100);

    isz = $urandom_range(32'h100, 32'hFFFFF);
    setup_phase($urandom, isz, isz + $urandom_range(0, 48));
    queue_random(120);

    setup_phase(32'h0, 32'h0, 32'h0);
    queue_random(60);

    isz = $urandom_range(0, 32'hFFFFFF);
    setup_phase($urandom, isz, isz + $urandom_range(0, 32'h400));
    queue_random(100);
    while (pending.size() > 60) @(posedge clk);
    no_gaps = 1'b1;

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
